/* src/lcp_pkg.sv */
// Shared types and constants for the link credit pacer.
`timescale 1ns / 1ps
`default_nettype none
package lcp_pkg;

    localparam int SIZE_W          = 16;
    localparam int SPEED_W         = 16;
    localparam int DELAY_W         = 16;
    localparam int CREDIT_W        = 10;
    localparam int NOW_W           = 32;
    localparam int REL_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int TIME_BITS_DEF   = 32;
    // dividend is at most 65535 + 1538 or 65535 + 65534, both fit 17 bits
    localparam int DIV_BITS        = 17;
    localparam logic [DIV_BITS-1:0] CREDIT_OVERHEAD = 17'd1538;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINK_SPEED   = 2'd0,
        CFG_PROP_DELAY   = 2'd1,
        CFG_CREDIT_LIMIT = 2'd2
    } cfg_idx_t;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_ARRIVAL = 1'b1;

    typedef struct packed {
        logic              command;
        logic              is_credit;
        logic [SIZE_W-1:0] packet_size;
        logic [NOW_W-1:0]  now_time;
    } lcp_in_t;

    typedef struct packed {
        logic             dropped;
        logic [REL_W-1:0] release_time;
    } lcp_out_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } lcp_div_res_t;

endpackage
`default_nettype wire

/* src/lcp_serial_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lcp_serial_div
    import lcp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [DIV_BITS-1:0] dividend,
    input  wire logic [SPEED_W-1:0]  divisor,
    output lcp_div_res_t             result
);

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_BITS-1:0] trial;
    logic                fits;

    assign trial = {rem_reg[DIV_BITS-2:0], dvd_reg[DIV_BITS-1]};
    assign fits  = trial >= DIV_BITS'(divisor);

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            cnt_next  = CNT_W'(DIV_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial - DIV_BITS'(divisor) : trial;
            dvd_next = {dvd_reg[DIV_BITS-2:0], 1'b0};
            quo_next = {quo_reg[DIV_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule
`default_nettype wire

/* src/lcp_out_stage.sv */
// Output register that holds one result beat until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module lcp_out_stage
    import lcp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load,
    input  wire lcp_out_t load_data,
    output logic          free,
    output logic          m_valid,
    input  wire logic     m_ready,
    output lcp_out_t      m_data
);

    logic     valid_reg, valid_next;
    lcp_out_t data_reg, data_next;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load && free) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
`default_nettype wire

/* src/link_credit_pacer_unit.sv */
// Top level of the link credit pacer: control sequencer and pacing state.
//
// Input channel s_valid/s_ready/s_data carries enqueue and arrival beats;
// result channel m_valid/m_ready/m_data returns one beat per enqueue and
// none per arrival. cfg_we/cfg_addr/cfg_wdata write link speed, propagation
// delay and credit limit; write them only while the block is idle.
// An enqueue that is not dropped, or a data arrival, runs the bit-serial
// divider by link speed. For an enqueue, the divider forms the 17 quotient
// bits at one bit per cycle; ST_TXTIME then forms the transmission time,
// ST_APPLY and ST_FINISH update the state and form the release time, and
// ST_EMIT loads the output register. m_valid and s_ready both rise at the
// same edge, so the result and the next item can be taken together.
// A data arrival returns to idle from ST_APPLY, with no result. A dropped
// credit goes straight to ST_EMIT without the divider; a credit arrival
// only lowers a nonzero credit count and leaves s_ready high.
// If the receiver stalls, the finished result waits in the output register
// while the next item is taken; a further result waits for that register.
// Reset (synchronous, active low) clears the credit count, next credit
// slot and backlog, and sets speed 1, delay 0, limit 8.
`timescale 1ns / 1ps
`default_nettype none
module link_credit_pacer_unit
    import lcp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lcp_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lcp_out_t                   m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_TXTIME,
        ST_APPLY,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [DELAY_W-1:0]     delay_reg, delay_next;
    logic [CREDIT_W-1:0]    limit_reg, limit_next;
    logic [CREDIT_W-1:0]    count_reg, count_next;
    logic [TIME_BITS-1:0]   slot_reg, slot_next;
    logic [TIME_BITS-1:0]   backlog_reg, backlog_next;
    logic                   cmd_reg, cmd_next;
    logic                   credit_reg, credit_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TIME_BITS-1:0]   step_reg, step_next;
    logic [TIME_BITS-1:0]   release_reg, release_next;
    logic                   drop_reg, drop_next;

    logic                   accept;
    logic                   div_start;
    logic [DIV_BITS-1:0]    dividend;
    lcp_div_res_t           div_res;
    logic                   out_load;
    logic                   out_free;
    lcp_out_t               out_beat;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // credit: floor((size + overhead) / speed); data: ceil(size / speed)
    assign dividend = s_data.is_credit
                    ? DIV_BITS'(s_data.packet_size) + CREDIT_OVERHEAD
                    : DIV_BITS'(s_data.packet_size) + DIV_BITS'(speed_reg)
                      - DIV_BITS'(1);

    always_comb begin
        state_next   = state_reg;
        speed_next   = speed_reg;
        delay_next   = delay_reg;
        limit_next   = limit_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        backlog_next = backlog_reg;
        cmd_next     = cmd_reg;
        credit_next  = credit_reg;
        now_next     = now_reg;
        step_next    = step_reg;
        release_next = release_reg;
        drop_next    = drop_reg;
        div_start    = 1'b0;
        out_load     = 1'b0;

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LINK_SPEED:   speed_next = SPEED_W'(cfg_wdata);
                CFG_PROP_DELAY:   delay_next = DELAY_W'(cfg_wdata);
                CFG_CREDIT_LIMIT: limit_next = CREDIT_W'(cfg_wdata);
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next    = s_data.command;
                    credit_next = s_data.is_credit;
                    now_next    = TIME_BITS'(s_data.now_time);
                    drop_next   = 1'b0;
                    if (s_data.is_credit && s_data.command == CMD_ARRIVAL) begin
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                    end else if (s_data.is_credit && count_reg >= limit_reg) begin
                        drop_next    = 1'b1;
                        release_next = '0;
                        state_next   = ST_EMIT;
                    end else begin
                        if (s_data.is_credit) begin
                            count_next = count_reg + 1'b1;
                        end
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_res.done) begin
                    state_next = ST_TXTIME;
                end
            end
            ST_TXTIME: begin
                // zero speed: zero step, so no transmission time or delay; slot stays at release
                if (speed_reg == '0) begin
                    step_next = '0;
                end else if (credit_reg) begin
                    step_next = TIME_BITS'(div_res.quotient);
                end else begin
                    step_next = TIME_BITS'(div_res.quotient) + TIME_BITS'(delay_reg);
                end
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (credit_reg) begin
                    release_next = (slot_reg > now_reg) ? slot_reg : now_reg;
                    state_next   = ST_FINISH;
                end else if (cmd_reg == CMD_ARRIVAL) begin
                    backlog_next = (backlog_reg > step_reg) ? backlog_reg - step_reg : '0;
                    state_next   = ST_IDLE;
                end else begin
                    backlog_next = backlog_reg + step_reg;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (credit_reg) begin
                    slot_next = release_reg + step_reg;
                end else begin
                    release_next = now_reg + backlog_reg;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_load = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            speed_reg   <= SPEED_W'(1);
            delay_reg   <= '0;
            limit_reg   <= CREDIT_W'(8);
            count_reg   <= '0;
            slot_reg    <= '0;
            backlog_reg <= '0;
        end else begin
            state_reg   <= state_next;
            speed_reg   <= speed_next;
            delay_reg   <= delay_next;
            limit_reg   <= limit_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            backlog_reg <= backlog_next;
        end
        cmd_reg     <= cmd_next;
        credit_reg  <= credit_next;
        now_reg     <= now_next;
        step_reg    <= step_next;
        release_reg <= release_next;
        drop_reg    <= drop_next;
    end

    assign out_beat.dropped      = drop_reg;
    assign out_beat.release_time = REL_W'(release_reg);

    lcp_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (speed_reg),
        .result   (div_res)
    );

    lcp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_beat),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

/* src/lcp_checker.sv */
// Port-level checks for the link credit pacer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lcp_checker
    import lcp_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire lcp_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire lcp_out_t m_data
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dropped |-> m_data.release_time == '0)
        else $error("dropped credit carries a release time");

    // data items go through the divider, so the input side must close
    a_data_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.is_credit |=> !s_ready)
        else $error("input ready while a data item is in work");

endmodule

bind link_credit_pacer_unit lcp_checker u_lcp_checker (.*);
`default_nettype wire
